// ----- design/pcbd_pkg.sv -----
// Shared types and constants of the prefix-code bit decoder.
package pcbd_pkg;

  localparam int BYTE_W      = 8;
  localparam int BITS_LEFT_W = $clog2(BYTE_W + 1);
  localparam int IDX_W       = 8;
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 16;
  localparam int LEN_W       = 5;

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 1;

  // input tuser bit positions
  localparam int TUSER_REQ   = 0;
  localparam int TUSER_START = 1;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_DECODE = 1'b1
  } req_e;

  // input tdata layout, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]        pad;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  entry_length;
    logic [CODE_W-1:0] entry_code;
    logic [SYM_W-1:0]  entry_symbol;
    logic [IDX_W-1:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_RESULT,
    ST_NEXT,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic shift;
    logic scan_init;
    logic scan_rd;
    logic capture;
    logic pend_load;
    logic push_mid;
    logic push_last;
  } dp_cmd_t;

  typedef struct packed {
    logic in_decode;
    logic sweep_last;
    logic issue_done;
    logic hit;
    logic scan_end;
    logic cnt_full;
    logic byte_done;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- design/pcbd_ctrl.sv -----
// Controller state machine of the prefix-code bit decoder.
module pcbd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  pcbd_pkg::dp_stat_t stat_i,
  output pcbd_pkg::dp_cmd_t  cmd_o
);
  import pcbd_pkg::*;

  state_e state_q, state_d;
  logic   found;

  assign found = stat_i.hit | (stat_i.scan_end & stat_i.cnt_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid_i && stat_i.in_decode) state_d = ST_SHIFT;
      end
      ST_SHIFT: state_d = ST_SCAN;
      ST_SCAN: begin
        if (found) begin
          state_d = ST_RESULT;
        end else if (stat_i.scan_end) begin
          state_d = ST_NEXT;
        end
      end
      ST_RESULT: begin
        if (!stat_i.pend_valid || stat_i.out_free) state_d = ST_NEXT;
      end
      ST_NEXT: begin
        state_d = stat_i.byte_done ? ST_FLUSH : ST_SHIFT;
      end
      ST_FLUSH: begin
        if (!stat_i.pend_valid || stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.accept = s_tvalid_i;
      end
      ST_SHIFT: begin
        cmd_o.shift     = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = !stat_i.issue_done && !stat_i.hit && !stat_i.scan_end;
        cmd_o.capture = found;
      end
      ST_RESULT: begin
        if (!stat_i.pend_valid) begin
          cmd_o.pend_load = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.push_mid  = 1'b1;
          cmd_o.pend_load = 1'b1;
        end
      end
      ST_NEXT: ;
      ST_FLUSH: begin
        cmd_o.push_last = stat_i.pend_valid && stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ----- design/pcbd_dp.sv -----
// Datapath of the prefix-code bit decoder: code table, bit accumulator, result registers.
module pcbd_dp #(
  parameter int TABLE_SIZE   = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pcbd_pkg::dp_cmd_t                    cmd_i,
  output pcbd_pkg::dp_stat_t                   stat_o,
  input  logic [pcbd_pkg::IN_TDATA_W-1:0]      in_data_i,
  input  logic [pcbd_pkg::IN_TUSER_W-1:0]      in_user_i,
  output logic                                 out_valid_o,
  output logic [pcbd_pkg::OUT_TDATA_W-1:0]     out_data_o,
  output logic [pcbd_pkg::OUT_TUSER_W-1:0]     out_user_o,
  output logic                                 out_last_o,
  input  logic                                 out_ready_i
);
  import pcbd_pkg::*;

  localparam int AddrW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CntW    = $clog2(MAX_CODE_LEN + 1);
  localparam int AccW    = MAX_CODE_LEN;
  localparam int CmpW    = (AccW > CODE_W) ? AccW : CODE_W;
  localparam int LCmpW   = (CntW > LEN_W) ? CntW : LEN_W;
  localparam int IdxCmpW = ((AddrW > IDX_W) ? AddrW : IDX_W) + 1;

  in_word_t in_word;
  req_e     req;
  logic     load_en, decode_en;

  entry_t             mem [TABLE_SIZE];
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  entry_t             wr_data;
  entry_t             rd_q;

  logic [AccW-1:0]        acc_q, acc_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [BYTE_W-1:0]      byte_q, byte_d;
  logic [BITS_LEFT_W-1:0] bits_left_q, bits_left_d;
  logic [AddrW-1:0]       sa_q, sa_d;
  logic                   issue_done_q, issue_done_d;
  logic                   rdv_q, rd_last_q;
  logic                   sa_last, match, hit;

  logic [SYM_W-1:0] res_sym_q, pend_sym_q, m_sym_q;
  logic             res_err_q, pend_err_q, m_err_q, m_last_q;
  logic             pend_valid_q, pend_valid_d;
  logic             m_valid_q, m_valid_d;
  logic             push;

  assign in_word   = in_word_t'(in_data_i);
  assign req       = req_e'(in_user_i[TUSER_REQ]);
  assign load_en   = cmd_i.accept && (req == REQ_LOAD) &&
                     (IdxCmpW'(in_word.entry_index) < IdxCmpW'(TABLE_SIZE));
  assign decode_en = cmd_i.accept && (req == REQ_DECODE);

  // table memory: one write port, one registered read port
  assign wr_en   = cmd_i.clr_wr | load_en;
  assign wr_addr = cmd_i.clr_wr ? sa_q : AddrW'(in_word.entry_index);
  always_comb begin
    wr_data = '0;
    if (!cmd_i.clr_wr) begin
      wr_data.sym  = in_word.entry_symbol;
      wr_data.code = in_word.entry_code;
      wr_data.len  = in_word.entry_length;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.scan_rd) rd_q <= mem[sa_q];
  end

  assign sa_last = (sa_q == AddrW'(TABLE_SIZE - 1));
  assign match   = (LCmpW'(rd_q.len) != '0) &&
                   (LCmpW'(rd_q.len) == LCmpW'(cnt_q)) &&
                   (CmpW'(rd_q.code) == CmpW'(acc_q));
  assign hit     = rdv_q && match;

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    byte_d       = byte_q;
    bits_left_d  = bits_left_q;
    sa_d         = sa_q;
    issue_done_d = issue_done_q;
    if (decode_en) begin
      byte_d      = in_word.data_byte;
      bits_left_d = BITS_LEFT_W'(BYTE_W);
      if (in_user_i[TUSER_START]) begin
        acc_d = '0;
        cnt_d = '0;
      end
    end
    if (cmd_i.shift) begin
      acc_d       = {acc_q[AccW-2:0], byte_q[BYTE_W-1]};
      cnt_d       = cnt_q + CntW'(1);
      byte_d      = {byte_q[BYTE_W-2:0], 1'b0};
      bits_left_d = bits_left_q - BITS_LEFT_W'(1);
    end
    if (cmd_i.capture) begin
      acc_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.scan_init) begin
      sa_d         = '0;
      issue_done_d = 1'b0;
    end
    if (cmd_i.clr_wr || cmd_i.scan_rd) begin
      sa_d = sa_last ? '0 : sa_q + AddrW'(1);
    end
    if (cmd_i.scan_rd && sa_last) issue_done_d = 1'b1;
  end

  assign push = cmd_i.push_mid | cmd_i.push_last;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.pend_load) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.push_last) begin
      pend_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (push) begin
      m_valid_d = 1'b1;
    end else if (out_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      cnt_q        <= '0;
      bits_left_q  <= '0;
      sa_q         <= '0;
      issue_done_q <= 1'b0;
      rdv_q        <= 1'b0;
      rd_last_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      cnt_q        <= cnt_d;
      bits_left_q  <= bits_left_d;
      sa_q         <= sa_d;
      issue_done_q <= issue_done_d;
      rdv_q        <= cmd_i.scan_rd;
      rd_last_q    <= cmd_i.scan_rd && sa_last;
      pend_valid_q <= pend_valid_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (cmd_i.capture) begin
      res_sym_q <= hit ? rd_q.sym : '0;
      res_err_q <= !hit;
    end
    if (push) begin
      m_sym_q  <= pend_sym_q;
      m_err_q  <= pend_err_q;
      m_last_q <= cmd_i.push_last;
    end
    if (cmd_i.pend_load) begin
      pend_sym_q <= res_sym_q;
      pend_err_q <= res_err_q;
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.in_decode  = (req == REQ_DECODE);
    stat_o.sweep_last = sa_last;
    stat_o.issue_done = issue_done_q;
    stat_o.hit        = hit;
    stat_o.scan_end   = rdv_q && rd_last_q;
    stat_o.cnt_full   = (cnt_q == CntW'(MAX_CODE_LEN));
    stat_o.byte_done  = (bits_left_q == '0);
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free   = !m_valid_q || out_ready_i;
  end

  assign out_valid_o = m_valid_q;
  assign out_data_o  = m_sym_q;
  assign out_user_o  = m_err_q;
  assign out_last_o  = m_last_q;

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!m_valid_q || out_ready_i))
    else $error("result pushed into a full output register");

  a_pend_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pend_load && pend_valid_q) |-> cmd_i.push_mid)
    else $error("pending result overwritten");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_CODE_LEN))
    else $error("bit count beyond maximum code length");

  a_capture_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> rdv_q)
    else $error("result captured without table read data");

  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !pend_valid_q)
    else $error("word accepted with a result still pending");
`endif

endmodule

// ----- design/prefix_code_bit_decoder.sv -----
// Top level of the prefix-code bit decoder.
//
// Input stream (s_axis): one word is either a table load (tuser[0] = 0) or a
// data byte to decode (tuser[0] = 1, tuser[1] = clear the bit accumulator first).
// A load writes one table slot in the cycle it is accepted; slots past the
// table size are dropped. A data byte is decoded MSB first, one bit at a time.
// Per bit: a shift state, then a sequential scan of the table memory (one slot
// per cycle, stops at the first match), then a result state when the bit
// yields a result, and a state to settle the bit.
// The worst case per byte is set by the table scan through the single read
// port. Only one byte is in work at a time; the next word is taken once the
// previous one is fully done.
// Output stream (m_axis): 0 to 8 result words per byte, tdata = symbol,
// tuser = error, tlast on the final result of the byte. A result is held back
// until the next result or the end of the byte is known.
// A registered output stage lets decoding go on while the receiver stalls,
// until a result is ready or the byte ends while the output stage is full and
// a result is held back. After reset the table lengths are cleared by a pass
// over every slot, during which s_axis_tready stays low.
module prefix_code_bit_decoder #(
  parameter int TABLE_SIZE   = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] entry_index, [15:8] entry_symbol, [31:16] entry_code,
  // [36:32] entry_length, [44:37] data_byte, [47:45] zero
  input  logic [pcbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] req_type, [1] stream_start
  input  logic [pcbd_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] symbol
  output logic [pcbd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // [0] error
  output logic [pcbd_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import pcbd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pcbd_dp #(
    .TABLE_SIZE   (TABLE_SIZE),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule

// ----- bench/prefix_code_bit_decoder_tb.sv -----
// Self-checking testbench of the prefix-code bit decoder: directed table, then random code sets.
`timescale 1ns / 1ps

module prefix_code_bit_decoder_tb;
  import pcbd_pkg::*;

  localparam int TBL_DEPTH       = 256;
  localparam int MAX_LEN         = 16;
  localparam int RAND_ITEMS      = 180;
  localparam int HOLD_OFF_CYCLES = 8000;
  localparam int DRAIN_CYCLES    = 8 * (TBL_DEPTH + 4) + 200;
  localparam int CYCLE_LIMIT     = 3_000_000;

  typedef struct packed {
    req_e     req;
    logic     start;
    in_word_t body;
  } word_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             err;
    logic             last;
  } dec_out_t;

  typedef struct {
    req_e              req;
    logic              start;
    logic [IDX_W-1:0]  idx;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    bit                typed;
    int                n;
    logic [SYM_W-1:0]  rsym;
    logic              rerr;
  } dir_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  // predictor state
  logic [SYM_W-1:0]  code_sym  [TBL_DEPTH];
  logic [CODE_W-1:0] code_bits [TBL_DEPTH];
  logic [LEN_W-1:0]  code_len  [TBL_DEPTH];
  logic [31:0]       acc_bits;
  int                acc_cnt;
  dec_out_t          step_out[$];
  dec_out_t          pending_results[$];

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  error_results = 0;
  int  words_sent    = 0;
  int  bytes_sent    = 0;
  int  rand_sent     = 0;
  int  gap_pct       = 20;
  int  cycle_cnt     = 0;
  bit  no_idle       = 1'b0;
  bit  hold_off_go   = 1'b0;
  bit  hold_off_done = 1'b0;
  dec_out_t head;

  prefix_code_bit_decoder #(
    .TABLE_SIZE  (TBL_DEPTH),
    .MAX_CODE_LEN(MAX_LEN)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  // Bit-serial decode of one word; results land in step_out.
  function automatic void decode_step(input word_t w);
    int hit;
    step_out.delete();
    if (w.req == REQ_LOAD) begin
      code_sym[w.body.entry_index]  = w.body.entry_symbol;
      code_bits[w.body.entry_index] = w.body.entry_code;
      code_len[w.body.entry_index]  = w.body.entry_length;
      return;
    end
    if (w.start) begin
      acc_bits = '0;
      acc_cnt  = 0;
    end
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      acc_bits = {acc_bits[30:0], w.body.data_byte[b]};
      acc_cnt++;
      hit = -1;
      for (int k = 0; k < TBL_DEPTH; k++) begin
        if (hit < 0 && code_len[k] != 0 && code_len[k] == acc_cnt &&
            {16'h0000, code_bits[k]} == acc_bits)
          hit = k;
      end
      if (hit >= 0) begin
        step_out.push_back('{sym: code_sym[hit], err: 1'b0, last: 1'b0});
        acc_bits = '0;
        acc_cnt  = 0;
      end else if (acc_cnt >= MAX_LEN) begin
        step_out.push_back('{sym: '0, err: 1'b1, last: 1'b0});
        acc_bits = '0;
        acc_cnt  = 0;
      end
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endfunction

  function automatic word_t load_word(input logic [7:0] idx, input logic [7:0] sym,
                                      input logic [15:0] code, input logic [4:0] len);
    word_t w;
    w.req   = REQ_LOAD;
    w.start = 1'($urandom_range(0, 1));
    w.body  = '{pad: '0, data_byte: 8'($urandom), entry_length: len, entry_code: code,
                entry_symbol: sym, entry_index: idx};
    return w;
  endfunction

  function automatic word_t decode_word(input logic [7:0] data, input logic start);
    word_t w;
    w.req   = REQ_DECODE;
    w.start = start;
    w.body  = '{pad: '0, data_byte: data, entry_length: 5'($urandom),
                entry_code: 16'($urandom), entry_symbol: 8'($urandom),
                entry_index: 8'($urandom)};
    return w;
  endfunction

  task automatic send_word(input word_t w, input bit from_model);
    logic [IN_TUSER_W-1:0] tuser_v;
    tuser_v              = '0;
    tuser_v[TUSER_REQ]   = w.req;
    tuser_v[TUSER_START] = w.start;
    if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tdata  <= w.body;
    s_axis_tuser  <= tuser_v;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_step(w);
    words_sent++;
    if (w.req == REQ_DECODE) bytes_sent++;
    if (from_model) begin
      foreach (step_out[i]) pending_results.push_back(step_out[i]);
    end
  endtask

  // receiver: random stalls, one long hold-off
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_off_go && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser[0]) error_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: exp none, got sym %h err %b last %b",
                 $time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        if (m_axis_tdata !== head.sym) begin
          $display("%0t: symbol: exp %h, got %h", $time, head.sym, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== head.err) begin
          $display("%0t: error flag: exp %b, got %b", $time, head.err, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tlast !== head.last) begin
          $display("%0t: tlast: exp %b, got %b", $time, head.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t      dir_rows[$];
    word_t         w;
    int            live_slots[$];
    logic [15:0]   leaf_code[$];
    int            leaf_len[$];
    bit [255:0]    slot_taken;
    int            depth_cap, n_split, pick, n_bytes, idx;
    bit            deep;
    logic [15:0]   c;

    for (int k = 0; k < TBL_DEPTH; k++) begin
      code_sym[k]  = '0;
      code_bits[k] = '0;
      code_len[k]  = '0;
    end
    acc_bits = '0;
    acc_cnt  = 0;

    dir_rows = '{
      // req        st    idx    sym    code      len    data   typed n  rsym   rerr
      '{REQ_DECODE, 1'b1, 8'h00, 8'h00, 16'h0000, 5'd0,  8'h00, 1, 0, 8'h00, 1'b0},
      '{REQ_DECODE, 1'b0, 8'h00, 8'h00, 16'h0000, 5'd0,  8'hFF, 1, 1, 8'h00, 1'b1},
      '{REQ_LOAD,   1'b1, 8'h00, 8'hA5, 16'h0001, 5'd1,  8'hFF, 1, 0, 8'h00, 1'b0},
      '{REQ_LOAD,   1'b0, 8'hFF, 8'hFF, 16'h0000, 5'd1,  8'h00, 1, 0, 8'h00, 1'b0},
      // entry fields ignored on decode
      '{REQ_DECODE, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 5'd31, 8'hFF, 1, 8, 8'hA5, 1'b0},
      '{REQ_DECODE, 1'b0, 8'h00, 8'h00, 16'h0000, 5'd0,  8'h00, 1, 8, 8'hFF, 1'b0},
      '{REQ_DECODE, 1'b0, 8'h00, 8'h00, 16'h0000, 5'd0,  8'hA5, 0, 0, 8'h00, 1'b0},
      '{REQ_LOAD,   1'b0, 8'h00, 8'h00, 16'h0000, 5'd0,  8'h00, 1, 0, 8'h00, 1'b0},
      '{REQ_LOAD,   1'b0, 8'hFF, 8'h00, 16'h0000, 5'd0,  8'h00, 1, 0, 8'h00, 1'b0},
      '{REQ_LOAD,   1'b0, 8'h0A, 8'h11, 16'hFFFF, 5'd16, 8'h00, 1, 0, 8'h00, 1'b0},
      // length above max, code wider than length, duplicate of a lower slot
      '{REQ_LOAD,   1'b0, 8'h14, 8'h22, 16'h0001, 5'd31, 8'h00, 1, 0, 8'h00, 1'b0},
      '{REQ_LOAD,   1'b0, 8'h1E, 8'h33, 16'h0002, 5'd1,  8'h00, 1, 0, 8'h00, 1'b0},
      '{REQ_LOAD,   1'b0, 8'h28, 8'h44, 16'hFFFF, 5'd16, 8'h00, 1, 0, 8'h00, 1'b0},
      '{REQ_DECODE, 1'b1, 8'h00, 8'h00, 16'h0000, 5'd0,  8'hFF, 1, 0, 8'h00, 1'b0},
      '{REQ_DECODE, 1'b0, 8'h00, 8'h00, 16'h0000, 5'd0,  8'hFF, 1, 1, 8'h11, 1'b0},
      '{REQ_DECODE, 1'b1, 8'h00, 8'h00, 16'h0000, 5'd0,  8'h00, 1, 0, 8'h00, 1'b0},
      '{REQ_DECODE, 1'b0, 8'h00, 8'h00, 16'h0000, 5'd0,  8'h00, 1, 1, 8'h00, 1'b1},
      '{REQ_LOAD,   1'b0, 8'h03, 8'h03, 16'h0002, 5'd2,  8'h00, 1, 0, 8'h00, 1'b0},
      '{REQ_LOAD,   1'b0, 8'h04, 8'h04, 16'h0002, 5'd2,  8'h00, 1, 0, 8'h00, 1'b0},
      '{REQ_DECODE, 1'b1, 8'h00, 8'h00, 16'h0000, 5'd0,  8'h80, 0, 0, 8'h00, 1'b0},
      '{REQ_DECODE, 1'b0, 8'h00, 8'h00, 16'h0000, 5'd0,  8'h5A, 0, 0, 8'h00, 1'b0},
      // start clears the 14 leftover bits
      '{REQ_DECODE, 1'b1, 8'h00, 8'h00, 16'h0000, 5'd0,  8'hA0, 0, 0, 8'h00, 1'b0},
      '{REQ_DECODE, 1'b0, 8'h00, 8'h00, 16'h0000, 5'd0,  8'hBF, 0, 0, 8'h00, 1'b0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      w.req   = dir_rows[r].req;
      w.start = dir_rows[r].start;
      w.body  = '{pad: '0, data_byte: dir_rows[r].data, entry_length: dir_rows[r].len,
                  entry_code: dir_rows[r].code, entry_symbol: dir_rows[r].sym,
                  entry_index: dir_rows[r].idx};
      send_word(w, !dir_rows[r].typed);
      if (dir_rows[r].typed) begin
        for (int i = 0; i < dir_rows[r].n; i++)
          pending_results.push_back('{sym: dir_rows[r].rsym, err: dir_rows[r].rerr,
                                      last: (i == dir_rows[r].n - 1)});
      end
      if (dir_rows[r].req == REQ_LOAD) live_slots.push_back(int'(dir_rows[r].idx));
    end

    for (int ph = 0; rand_sent < RAND_ITEMS; ph++) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase

      // retire the previous code set
      while (live_slots.size() != 0) begin
        send_word(load_word(8'(live_slots.pop_front()), 8'($urandom), 16'($urandom), 5'd0),
                  1'b1);
        rand_sent++;
      end

      // random prefix code by repeated leaf splitting
      leaf_code.delete();
      leaf_len.delete();
      leaf_code.push_back('0);
      leaf_len.push_back(0);
      deep      = ($urandom_range(0, 3) == 0);
      depth_cap = deep ? MAX_LEN : $urandom_range(2, 6);
      n_split   = deep ? $urandom_range(12, 16) : $urandom_range(1, 10);
      for (int s = 0; s < n_split; s++) begin
        pick = deep ? leaf_len.size() - 1 : $urandom_range(0, leaf_len.size() - 1);
        if (leaf_len[pick] < depth_cap) begin
          c               = leaf_code[pick];
          leaf_code[pick] = c << 1;
          leaf_len[pick]  = leaf_len[pick] + 1;
          leaf_code.push_back((c << 1) | 16'h0001);
          leaf_len.push_back(leaf_len[pick]);
        end
      end
      if (leaf_len.size() > 2 && $urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, leaf_len.size() - 1);
        leaf_code.delete(pick);
        leaf_len.delete(pick);
      end

      slot_taken = '0;
      foreach (leaf_len[i]) begin
        do idx = $urandom_range(0, TBL_DEPTH - 1); while (slot_taken[idx]);
        slot_taken[idx] = 1'b1;
        live_slots.push_back(idx);
        send_word(load_word(8'(idx), 8'($urandom), leaf_code[i], 5'(leaf_len[i])), 1'b1);
        rand_sent++;
        if ($urandom_range(0, 9) == 0) begin
          do idx = $urandom_range(0, TBL_DEPTH - 1); while (slot_taken[idx]);
          slot_taken[idx] = 1'b1;
          live_slots.push_back(idx);
          send_word(load_word(8'(idx), 8'($urandom), leaf_code[i], 5'(leaf_len[i])), 1'b1);
          rand_sent++;
        end
      end
      if ($urandom_range(0, 6) == 0) begin
        idx = $urandom_range(0, TBL_DEPTH - 1);
        live_slots.push_back(idx);
        send_word(load_word(8'(idx), 8'($urandom), 16'($urandom),
                            5'($urandom_range(0, 31))), 1'b1);
        rand_sent++;
      end

      if (ph == 1) hold_off_go = 1'b1;
      if (ph == 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end

      n_bytes = $urandom_range(6, 24);
      for (int b = 0; b < n_bytes; b++) begin
        if ($urandom_range(0, 19) == 0) begin
          w.req   = req_e'($urandom_range(0, 1));
          w.start = 1'($urandom_range(0, 1));
          w.body  = {3'b000, 45'({$urandom, $urandom})};
          if (w.req == REQ_LOAD) live_slots.push_back(int'(w.body.entry_index));
        end else begin
          w = decode_word((deep && $urandom_range(0, 1)) ? 8'hFF : 8'($urandom),
                          (b == 0) || ($urandom_range(0, 9) == 0));
        end
        send_word(w, 1'b1);
        rand_sent++;
        if (rand_sent >= RAND_ITEMS - 35) no_idle = 1'b1;
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatches += pending_results.size();
    end

    $display("Run covered %0d words (%0d data bytes) over random code sets up to 16 bits,",
             words_sent, bytes_sent);
    $display("with %0d results checked, %0d of them code errors, and one long output stall.",
             results_seen, error_results);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- prefix_code_bit_decoder.f -----
design/pcbd_pkg.sv
design/pcbd_ctrl.sv
design/pcbd_dp.sv
design/prefix_code_bit_decoder.sv
bench/prefix_code_bit_decoder_tb.sv
